// ===== hdl/glcw_pkg.sv =====
// ----------------------------------------------------------------------------
// glcw_pkg
// Shared widths and types for the grid line cell walker.
// ----------------------------------------------------------------------------
`default_nettype none

package glcw_pkg;

    localparam int COORD_W = 5;   // row or column index on the grid
    localparam int DELTA_W = 6;   // signed end minus start, one axis
    localparam int OFS_W   = 8;   // signed walk offset from the start cell
    localparam int PROD_W  = OFS_W + DELTA_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int CNT_W   = 6;   // step count and step budget

    typedef logic signed [OFS_W-1:0]   t_ofs;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;

    // Operands handed to the shared multiplier.
    typedef struct packed {
        logic [OFS_W-1:0]   a;
        logic [DELTA_W-1:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

// ===== hdl/glcw_cross_unit.sv =====
// ----------------------------------------------------------------------------
// glcw_cross_unit
// Shared signed multiplier with a registered product, used for both terms
// of the cross product in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module glcw_cross_unit (
    input  wire logic              i_clk,
    input  wire glcw_pkg::t_mul_req i_req,
    output glcw_pkg::t_prod        o_prod
);

    glcw_pkg::t_prod r_prod;

    // Both operands are sign-extended to the product width before the multiply.
    always_ff @(posedge i_clk) begin
        r_prod <= glcw_pkg::t_prod'($signed(i_req.a)) * glcw_pkg::t_prod'($signed(i_req.b));
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hdl/grid_line_cell_walker_core.sv =====
// ----------------------------------------------------------------------------
// grid_line_cell_walker_core
// Walks the grid cells crossed by a segment and emits one cell per result.
// ----------------------------------------------------------------------------
// For each emitted cell the one multiplier forms ci*dc, then rc*dr, then the
// sign test steps the walk and loads the output register. A request with N
// cells (N up to 62) holds o_stall high throughout, also while the result side
// holds a cell back. Degenerate requests emit no cell.
// Synchronous active-low reset returns to idle and empties the output register.
`default_nettype none

module grid_line_cell_walker_core #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [4:0] i_start_row,
    input  wire logic [4:0] i_start_col,
    input  wire logic [4:0] i_end_row,
    input  wire logic [4:0] i_end_col,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [4:0]      o_cell_row,
    output logic [4:0]      o_cell_col,
    output logic            o_last_cell
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL_A = 2'd1;
    localparam logic [1:0] ST_MUL_B = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [8:0] GRID_LIM = 9'(GRID_SIZE);

    logic [1:0]                      r_state, n_state;
    logic [glcw_pkg::COORD_W-1:0]    r_sr, r_sc;
    glcw_pkg::t_delta                r_dr, r_dc;
    logic signed [1:0]               r_di, r_dj;
    logic [glcw_pkg::CNT_W-1:0]      r_budget, r_count;
    glcw_pkg::t_ofs                  r_rr, r_rc;
    glcw_pkg::t_prod                 r_p1;
    logic                            r_out_valid;
    logic [4:0]                      r_out_row, r_out_col;
    logic                            r_out_last;

    glcw_pkg::t_mul_req              mul_req;
    glcw_pkg::t_prod                 prod;

    glcw_pkg::t_delta                in_dr, in_dc;
    logic [glcw_pkg::DELTA_W-2:0]    abs_dr, abs_dc;
    logic                            off_grid, in_take;
    glcw_pkg::t_ofs                  di_x, dj_x, ci, nxt_rr, nxt_rc;
    glcw_pkg::t_ofs                  dr_x, dc_x;
    glcw_pkg::t_cross                cross_a, cross_b, djdr;
    logic                            a_pos, a_neg, b_pos, b_neg;
    logic [glcw_pkg::CNT_W-1:0]      nxt_count;
    logic                            walk_done, out_free, out_load;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == ST_EMIT) && out_free;

    // Request decode.
    assign in_dr    = glcw_pkg::t_delta'({1'b0, i_end_row})
                    - glcw_pkg::t_delta'({1'b0, i_start_row});
    assign in_dc    = glcw_pkg::t_delta'({1'b0, i_end_col})
                    - glcw_pkg::t_delta'({1'b0, i_start_col});
    assign abs_dr   = in_dr[glcw_pkg::DELTA_W-1] ? 5'(-in_dr) : in_dr[4:0];
    assign abs_dc   = in_dc[glcw_pkg::DELTA_W-1] ? 5'(-in_dc) : in_dc[4:0];
    assign off_grid = ({4'd0, i_start_row} >= GRID_LIM) || ({4'd0, i_start_col} >= GRID_LIM)
                   || ({4'd0, i_end_row} >= GRID_LIM) || ({4'd0, i_end_col} >= GRID_LIM);

    // Walk arithmetic.
    assign di_x = glcw_pkg::t_ofs'(r_di);
    assign dj_x = glcw_pkg::t_ofs'(r_dj);
    assign dr_x = glcw_pkg::t_ofs'(r_dr);
    assign dc_x = glcw_pkg::t_ofs'(r_dc);
    assign ci   = r_rr + di_x;

    // The rc*dr operands stay applied while a cell waits in ST_EMIT, so the
    // registered product is still valid when the result side releases it.
    always_comb begin
        mul_req.a = ci;
        mul_req.b = r_dc;
        if (r_state == ST_MUL_B || r_state == ST_EMIT) begin
            mul_req.a = r_rc;
            mul_req.b = r_dr;
        end
    end

    glcw_cross_unit u_cross (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // The second cross product differs from the first only by dj*dr.
    always_comb begin
        djdr = '0;
        if (r_dj == 2'sd1) begin
            djdr = glcw_pkg::t_cross'(r_dr);
        end else if (r_dj == -2'sd1) begin
            djdr = -glcw_pkg::t_cross'(r_dr);
        end
    end

    assign cross_a = glcw_pkg::t_cross'(r_p1) - glcw_pkg::t_cross'(prod);
    assign cross_b = cross_a - djdr;
    assign a_neg   = cross_a[glcw_pkg::CROSS_W-1];
    assign a_pos   = !a_neg && (cross_a != '0);
    assign b_neg   = cross_b[glcw_pkg::CROSS_W-1];
    assign b_pos   = !b_neg && (cross_b != '0);

    always_comb begin
        nxt_rr = r_rr;
        nxt_rc = r_rc;
        if ((a_pos && b_pos) || (a_neg && b_neg)) begin
            nxt_rc = r_rc + dj_x;
        end else if ((a_pos && b_neg) || (a_neg && b_pos)) begin
            nxt_rr = r_rr + di_x;
        end else begin
            nxt_rr = r_rr + di_x;
            nxt_rc = r_rc + dj_x;
        end
    end

    assign nxt_count = r_count + 1'b1;
    assign walk_done = ((nxt_rr == dr_x) && (nxt_rc == dc_x)) || (nxt_count >= r_budget);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && !off_grid && ((in_dr != '0) || (in_dc != '0))) begin
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = walk_done ? ST_IDLE : ST_MUL_A;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_take) begin
            r_sr     <= i_start_row;
            r_sc     <= i_start_col;
            r_dr     <= in_dr;
            r_dc     <= in_dc;
            r_di     <= (in_dr == '0) ? 2'sd0 : (in_dr[glcw_pkg::DELTA_W-1] ? -2'sd1 : 2'sd1);
            r_dj     <= (in_dc == '0) ? 2'sd0 : (in_dc[glcw_pkg::DELTA_W-1] ? -2'sd1 : 2'sd1);
            r_budget <= glcw_pkg::CNT_W'({1'b0, abs_dr} + {1'b0, abs_dc});
            r_count  <= '0;
            r_rr     <= '0;
            r_rc     <= '0;
        end
        if (r_state == ST_MUL_B) begin
            r_p1 <= prod;
        end
        if (out_load) begin
            r_out_row  <= r_sr + r_rr[4:0];
            r_out_col  <= r_sc + r_rc[4:0];
            r_out_last <= walk_done;
            r_rr       <= nxt_rr;
            r_rc       <= nxt_rc;
            r_count    <= nxt_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cell_row  = r_out_row;
    assign o_cell_col  = r_out_col;
    assign o_last_cell = r_out_last;

    // The walk never runs past its step budget.
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_count < r_budget))
        else $error("walk step count reached its budget while busy");

    // The second product is only formed right after the first.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_B) |-> ($past(r_state) == ST_MUL_A))
        else $error("multiplier sequence out of order");

    // A cell loaded into the output register is presented next cycle.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("loaded cell not presented");

    // The final cell of a walk returns the sequencer to idle.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && walk_done) |=> (r_state == ST_IDLE) && o_last_cell)
        else $error("walk did not end on its last cell");

endmodule

`default_nettype wire
